@@ design/mma_pkg.sv @@
// Shared types and constants for the multichannel moving average unit.
package mma_pkg;

  // Field widths fixed by the item format
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned NCH_W      = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd3;

  // Register reset values
  localparam logic [NCH_W-1:0]      RST_ACTIVE = 4'd8;
  localparam logic [LEN_W-1:0]      RST_WINDOW = 5'd16;
  localparam logic [CFG_DATA_W-1:0] RST_DECAY  = 17'h08000;

  // 1.0 in unsigned 1.16
  localparam logic [CFG_DATA_W-1:0] ALPHA_ONE = 17'h10000;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_READOUT = 1'b1
  } op_e;

  typedef enum logic {
    MODE_SMA  = 1'b0,
    MODE_EWMA = 1'b1
  } mode_e;

  // One queued item, front to back
  typedef struct packed {
    op_e                 op;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  // Effective (clamped) configuration
  typedef struct packed {
    mode_e                 mode;
    logic [NCH_W-1:0]      nch;
    logic [LEN_W-1:0]      len;
    logic [CFG_DATA_W-1:0] alpha;
  } cfg_t;

endpackage

@@ design/mma_front.sv @@
// Front end: accepts items, drops samples on inactive channels, feeds the queue.
module mma_front
  import mma_pkg::*;
(
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [NCH_W-1:0]    nch_i,
  input  logic                q_full_i,
  output logic                push_o,
  output item_t               item_o
);

  op_e  op;
  logic active;
  logic keep;

  // Classify: readouts always go on, samples only for active channels
  assign op     = op_e'(operation_i);
  assign active = NCH_W'(channel_i) < nch_i;
  assign keep   = (op == OP_READOUT) || active;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

  // Readout carries channel 0 so the back never indexes past its arrays
  always_comb begin
    item_o.op      = op;
    item_o.channel = (op == OP_READOUT) ? '0 : channel_i;
    item_o.sample  = sample_i;
  end

endmodule

@@ design/mma_queue.sv @@
// Two-entry item queue between front and back.
module mma_queue
  import mma_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t      ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = ent_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ design/mma_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module mma_div #(
  parameter int unsigned DVD_W = 20,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned IT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [IT_W-1:0]  iter_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             q_bit;

  // One trial subtraction per cycle
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IT_W'(DVD_W - 1);
      end else if (busy_q) begin
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          iter_q <= iter_q - IT_W'(1);
        end
      end
    end
  end

  // Datapath: dividend shifts out, quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

endmodule

@@ design/mma_back.sv @@
// Back end: per-channel averaging state, sample updates and readout sequencing.
module mma_back
  import mma_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned MAX_WINDOW   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_empty_i,
  input  item_t               q_item_i,
  output logic                q_pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [CHAN_W-1:0]   out_channel_o,
  output logic [SAMPLE_W-1:0] average_o,
  output logic                no_samples_o,
  output logic                last_o
);

  localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SLOT_W = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned NPR_W  = CFG_DATA_W + SAMPLE_W;
  localparam int unsigned MPR_W  = CFG_DATA_W + ACC_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SMA_UPD  = 8'b0000_0010,
    S_EW_OLD   = 8'b0000_0100,
    S_EW_NEW   = 8'b0000_1000,
    S_EW_ADD   = 8'b0001_0000,
    S_RD_START = 8'b0010_0000,
    S_RD_DIV   = 8'b0100_0000,
    S_RD_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Per-channel state
  logic [SUM_W-1:0]  sum_q   [NUM_CHANNELS];
  logic [SLOT_W-1:0] wslot_q [NUM_CHANNELS];
  logic [CNT_W-1:0]  cnt_q   [NUM_CHANNELS];
  logic [CNT_W-1:0]  hw_q    [NUM_CHANNELS];
  logic [ACC_W-1:0]  acc_q   [NUM_CHANNELS];

  // Window memory; entries at or above a channel's fill mark read as zero
  logic [SAMPLE_W-1:0] win_mem [NUM_CHANNELS][MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_q;

  // Item being worked on
  logic [CH_W-1:0]     ch_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SAMPLE_W-1:0] x_q;
  logic [MPR_W-1:0]    mprod_q;
  logic [NPR_W-1:0]    nprod_q;

  // Readout
  logic [CH_W-1:0]     rd_idx_q;
  logic [SAMPLE_W-1:0] res_avg_q;
  logic                res_none_q;

  // Output register
  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_channel_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic                out_none_q;
  logic                out_last_q;

  logic                sma_wr;
  logic                ew_wr;
  logic                cnt_inc;
  logic                clear_all;
  logic                div_start;
  logic                out_load;
  logic                out_free;

  logic [CNT_W-1:0]    len_c;
  logic [CH_W-1:0]     hd_ch;
  logic [SLOT_W-1:0]   hd_slot;
  logic [SAMPLE_W-1:0] old_val;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    slot_nx;
  logic [SLOT_W-1:0]   wslot_new;
  logic [CNT_W-1:0]    hw_new;
  logic [CFG_DATA_W-1:0] beta;
  logic [ACC_W+1:0]    ew_sum;
  logic [NCH_W:0]      rd_next;
  logic                rd_last;
  logic                rd_none;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [SAMPLE_W-1:0] div_sat;

  assign len_c = CNT_W'(cfg_i.len);

  // Slot of the head item, restarted when the window has shrunk below it
  assign hd_ch   = CH_W'(q_item_i.channel);
  assign hd_slot = (CNT_W'(wslot_q[hd_ch]) >= len_c) ? '0 : wslot_q[hd_ch];

  // Simple average update
  assign old_val   = (CNT_W'(slot_q) < hw_q[ch_q]) ? rd_q : '0;
  assign sum_new   = sum_q[ch_q] - SUM_W'(old_val) + SUM_W'(x_q);
  assign slot_nx   = CNT_W'(slot_q) + CNT_W'(1);
  assign wslot_new = (slot_nx >= len_c) ? '0 : SLOT_W'(slot_nx);
  assign hw_new    = (CNT_W'(slot_q) >= hw_q[ch_q]) ? slot_nx : hw_q[ch_q];

  // Exponential update: a*x + ((1-a)*old >> 16)
  assign beta   = ALPHA_ONE - cfg_i.alpha;
  assign ew_sum = (ACC_W + 2)'(nprod_q) + (ACC_W + 2)'(mprod_q[MPR_W-1:16]);

  // Readout bookkeeping
  assign rd_next = (NCH_W + 1)'(rd_idx_q) + (NCH_W + 1)'(1);
  assign rd_last = rd_next == {1'b0, cfg_i.nch};
  assign rd_none = cnt_q[rd_idx_q] == '0;
  assign div_sat = (|div_quo[SUM_W-1:SAMPLE_W]) ? '1 : div_quo[SAMPLE_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  mma_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[rd_idx_q]),
    .divisor_i  (cnt_q[rd_idx_q]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    sma_wr    = 1'b0;
    ew_wr     = 1'b0;
    cnt_inc   = 1'b0;
    clear_all = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == OP_READOUT) begin
            state_d = S_RD_START;
          end else if (cfg_i.mode == MODE_EWMA) begin
            state_d = S_EW_OLD;
          end else begin
            state_d = S_SMA_UPD;
          end
        end
      end
      S_SMA_UPD: begin
        sma_wr  = 1'b1;
        cnt_inc = 1'b1;
        state_d = S_IDLE;
      end
      S_EW_OLD: state_d = S_EW_NEW;
      S_EW_NEW: state_d = S_EW_ADD;
      S_EW_ADD: begin
        ew_wr   = 1'b1;
        cnt_inc = 1'b1;
        state_d = S_IDLE;
      end
      S_RD_START: begin
        if (cfg_i.mode == MODE_SMA && !rd_none) begin
          div_start = 1'b1;
          state_d   = S_RD_DIV;
        end else begin
          state_d = S_RD_EMIT;
        end
      end
      S_RD_DIV: begin
        if (div_done) state_d = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_last) begin
            clear_all = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = S_RD_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_all) begin
        rd_idx_q <= '0;
      end else if (out_load) begin
        rd_idx_q <= rd_next[CH_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-channel state, cleared at once after a readout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sum_q[c]   <= '0;
        wslot_q[c] <= '0;
        cnt_q[c]   <= '0;
        hw_q[c]    <= '0;
        acc_q[c]   <= '0;
      end
    end else if (clear_all) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sum_q[c]   <= '0;
        wslot_q[c] <= '0;
        cnt_q[c]   <= '0;
        hw_q[c]    <= '0;
        acc_q[c]   <= '0;
      end
    end else begin
      if (sma_wr) begin
        sum_q[ch_q]   <= sum_new;
        wslot_q[ch_q] <= wslot_new;
        hw_q[ch_q]    <= hw_new;
      end
      if (ew_wr) begin
        acc_q[ch_q] <= ew_sum[ACC_W-1:0];
      end
      if (cnt_inc && (cnt_q[ch_q] < len_c)) begin
        cnt_q[ch_q] <= cnt_q[ch_q] + CNT_W'(1);
      end
    end
  end

  // Window memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (sma_wr) begin
      win_mem[ch_q][slot_q] <= x_q;
    end
    rd_q <= win_mem[hd_ch][hd_slot];
  end

  // Item capture, products and readout results
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ch_q   <= hd_ch;
      slot_q <= hd_slot;
      x_q    <= q_item_i.sample;
    end
    if (state_q == S_EW_OLD) begin
      mprod_q <= MPR_W'(beta) * MPR_W'(acc_q[ch_q]);
    end
    if (state_q == S_EW_NEW) begin
      nprod_q <= NPR_W'(cfg_i.alpha) * NPR_W'(x_q);
    end
    if (state_q == S_RD_START) begin
      res_none_q <= rd_none;
      res_avg_q  <= (rd_none || cfg_i.mode == MODE_SMA) ? '0 :
                    acc_q[rd_idx_q][ACC_W-1:ACC_W-SAMPLE_W];
    end else if (state_q == S_RD_DIV && div_done) begin
      res_avg_q <= div_sat;
    end
    if (out_load) begin
      out_channel_q <= CHAN_W'(rd_idx_q);
      out_avg_q     <= res_avg_q;
      out_none_q    <= res_none_q;
      out_last_q    <= rd_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign average_o     = out_avg_q;
  assign no_samples_o  = out_none_q;
  assign last_o        = out_last_q;

endmodule

@@ design/multichannel_moving_average_unit.sv @@
// Top level: configuration registers, front end, item queue and back end.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   operation_i, channel_i, sample_i
//   out       output     out_valid_o / out_stall_i out_channel_o, average_o,
//                                                  no_samples_o, last_o
//   cfg       input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Simple-mode sample: the item is taken with the window read, then the sum is updated.
// Exponential sample: the item is taken, then two multiplies in sequence, then the add.
// Readout: the item is taken, then each channel is started and emitted in turn, plus a serial
// divider pass for a simple-mode channel with samples (dividend SUM_W = 16 + log2 MAX_WINDOW).
// Reset is asynchronous; all channel state clears at once, no clearing pass.
// A 2-item queue lets the input run ahead while results wait on out_stall_i.
module multichannel_moving_average_unit
  import mma_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned MAX_WINDOW   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAN_W-1:0]     out_channel_o,
  output logic [SAMPLE_W-1:0]   average_o,
  output logic                  no_samples_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  mode_e                 mode_q;
  logic [NCH_W-1:0]      active_q;
  logic [LEN_W-1:0]      winlen_q;
  logic [CFG_DATA_W-1:0] decay_q;
  cfg_t                  cfg_eff;
  logic [NCH_W-1:0]      last_ch;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_in;
  item_t q_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SMA;
      active_q <= RST_ACTIVE;
      winlen_q <= RST_WINDOW;
      decay_q  <= RST_DECAY;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q   <= mode_e'(cfg_wdata_i[0]);
        CFG_ACTIVE: active_q <= cfg_wdata_i[NCH_W-1:0];
        CFG_WINDOW: winlen_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_DECAY:  decay_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp registers to their usable ranges
  always_comb begin
    cfg_eff.mode = mode_q;
    if (active_q == '0) begin
      cfg_eff.nch = NCH_W'(1);
    end else if ({1'b0, active_q} > (NCH_W + 1)'(NUM_CHANNELS)) begin
      cfg_eff.nch = NCH_W'(NUM_CHANNELS);
    end else begin
      cfg_eff.nch = active_q;
    end
    if (winlen_q == '0) begin
      cfg_eff.len = LEN_W'(1);
    end else if (9'(winlen_q) > 9'(MAX_WINDOW)) begin
      cfg_eff.len = LEN_W'(MAX_WINDOW);
    end else begin
      cfg_eff.len = winlen_q;
    end
    cfg_eff.alpha = (decay_q > ALPHA_ONE) ? ALPHA_ONE : decay_q;
  end

  mma_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .nch_i       (cfg_eff.nch),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .item_o      (q_in)
  );

  mma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  mma_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_eff),
    .q_empty_i     (q_empty),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_channel_o (out_channel_o),
    .average_o     (average_o),
    .no_samples_o  (no_samples_o),
    .last_o        (last_o)
  );

  assign last_ch = cfg_eff.nch - NCH_W'(1);

  // A channel without samples reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_samples_o |-> average_o == '0)
    else $error("no_samples result with nonzero average");

  // The closing result of a readout is on the highest active channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_channel_o == last_ch[CHAN_W-1:0])
    else $error("last flag on wrong channel");

endmodule

@@ test/mma_checker.sv @@
// Checker: predicts the per-channel averages from the observed items and checks each result.
module mma_checker
  import mma_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned MAX_WINDOW   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  operation_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CHAN_W-1:0]     out_channel_i,
  input  logic [SAMPLE_W-1:0]   average_i,
  input  logic                  no_samples_i,
  input  logic                  last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  localparam int unsigned SLOT_W  = $clog2(MAX_WINDOW);
  localparam int unsigned COUNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);

  // One expected readout result
  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] avg;
    logic                empty;
    logic                last;
  } readout_t;

  readout_t readout_q[$];
  int unsigned err_cnt;

  // Register shadows, raw as written
  mode_e                 mode_q;
  logic [NCH_W-1:0]      active_q;
  logic [LEN_W-1:0]      window_q;
  logic [CFG_DATA_W-1:0] decay_q;

  // Per-channel averaging state
  logic [SAMPLE_W-1:0] win_mem [NUM_CHANNELS][MAX_WINDOW];
  logic [SUM_W-1:0]    sum_q   [NUM_CHANNELS];
  logic [SLOT_W-1:0]   slot_q  [NUM_CHANNELS];
  logic [COUNT_W-1:0]  count_q [NUM_CHANNELS];
  logic [31:0]         ewma_q  [NUM_CHANNELS];

  function automatic int unsigned used_channels();
    if (active_q == 0) return 1;
    if (active_q > NUM_CHANNELS) return NUM_CHANNELS;
    return active_q;
  endfunction

  function automatic int unsigned used_window();
    if (window_q == 0) return 1;
    if (window_q > MAX_WINDOW) return MAX_WINDOW;
    return window_q;
  endfunction

  function automatic void wipe_channels();
    for (int unsigned c = 0; c < NUM_CHANNELS; c++) begin
      for (int unsigned s = 0; s < MAX_WINDOW; s++) win_mem[c][s] = '0;
      sum_q[c]   = '0;
      slot_q[c]  = '0;
      count_q[c] = '0;
      ewma_q[c]  = '0;
    end
  endfunction

  // Fold one sample into its channel; inactive channels are dropped
  function automatic void take_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] x);
    int unsigned len;
    int unsigned slot;
    logic [CFG_DATA_W-1:0] alpha;
    logic [63:0] acc;
    len = used_window();
    if (ch >= used_channels()) return;
    if (mode_q == MODE_SMA) begin
      slot = slot_q[ch];
      if (slot >= len) slot = 0;
      sum_q[ch] = sum_q[ch] - win_mem[ch][slot] + x;
      win_mem[ch][slot] = x;
      slot++;
      if (slot >= len) slot = 0;
      slot_q[ch] = SLOT_W'(slot);
    end else begin
      alpha = (decay_q > ALPHA_ONE) ? ALPHA_ONE : decay_q;
      acc = ((64'(alpha) * 64'(x)) << 16) + (64'(ALPHA_ONE) - 64'(alpha)) * 64'(ewma_q[ch]);
      ewma_q[ch] = acc[47:16];
    end
    // count advances in both modes, capped at the window
    if (count_q[ch] < len) count_q[ch] = count_q[ch] + 1'b1;
  endfunction

  // Queue one result per active channel, then clear everything
  function automatic void read_out();
    int unsigned nch;
    readout_t r;
    logic [SUM_W-1:0] quo;
    nch = used_channels();
    for (int unsigned i = 0; i < nch; i++) begin
      r.chan  = CHAN_W'(i);
      r.empty = (count_q[i] == 0);
      r.last  = (i + 1 == nch);
      if (r.empty) begin
        r.avg = '0;
      end else if (mode_q == MODE_SMA) begin
        quo = sum_q[i] / count_q[i];
        r.avg = (quo > SUM_W'(16'hFFFF)) ? 16'hFFFF : quo[SAMPLE_W-1:0];
      end else begin
        r.avg = ewma_q[i][31:16];
      end
      readout_q.push_back(r);
    end
    wipe_channels();
  endfunction

  function automatic void check_result();
    readout_t want;
    if (readout_q.size() == 0) begin
      $error("unexpected result: out_channel %0d average %0d", out_channel_i, average_i);
      err_cnt++;
      return;
    end
    want = readout_q.pop_front();
    if (out_channel_i !== want.chan) begin
      $error("out_channel: expected %0d, got %0d", want.chan, out_channel_i);
      err_cnt++;
    end
    if (average_i !== want.avg) begin
      $error("average: expected %0d, got %0d", want.avg, average_i);
      err_cnt++;
    end
    if (no_samples_i !== want.empty) begin
      $error("no_samples: expected %0d, got %0d", want.empty, no_samples_i);
      err_cnt++;
    end
    if (last_i !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, last_i);
      err_cnt++;
    end
  endfunction

  // Watch all three ports at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = MODE_SMA;
      active_q = RST_ACTIVE;
      window_q = RST_WINDOW;
      decay_q  = RST_DECAY;
      wipe_channels();
      readout_q.delete();
      err_cnt  = 0;
    end else begin
      // results first: they stem from items taken at earlier edges
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:   mode_q   = mode_e'(cfg_wdata_i[0]);
          CFG_ACTIVE: active_q = cfg_wdata_i[NCH_W-1:0];
          CFG_WINDOW: window_q = cfg_wdata_i[LEN_W-1:0];
          CFG_DECAY:  decay_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_e'(operation_i) == OP_READOUT) read_out();
        else take_sample(channel_i, sample_i);
      end
    end
    pending_o <= readout_q.size();
    errors_o  <= err_cnt;
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, item and register stimulus, and the final verdict.
module tb_top;
  import mma_pkg::*;

  localparam int unsigned NUM_CH       = 8;
  localparam int unsigned WIN_MAX      = 16;
  localparam int unsigned SETTLE       = 64;
  localparam int unsigned LIMIT        = 400000;
  localparam int unsigned RANDOM_ITEMS = 380;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_stall;
  op_e                   operation;
  logic [CHAN_W-1:0]     channel;
  logic [SAMPLE_W-1:0]   sample;
  logic                  out_valid;
  logic                  out_stall;
  logic [CHAN_W-1:0]     out_channel;
  logic [SAMPLE_W-1:0]   average;
  logic                  no_samples;
  logic                  last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycles = 0;
  int unsigned cur_nch = NUM_CH;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  multichannel_moving_average_unit #(
    .NUM_CHANNELS(NUM_CH),
    .MAX_WINDOW  (WIN_MAX)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .channel_i    (channel),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_channel_o(out_channel),
    .average_o    (average),
    .no_samples_o (no_samples),
    .last_o       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  mma_checker #(
    .NUM_CHANNELS(NUM_CH),
    .MAX_WINDOW  (WIN_MAX)
  ) avg_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operation_i  (operation),
    .channel_i    (channel),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_channel_i(out_channel),
    .average_i    (average),
    .no_samples_i (no_samples),
    .last_i       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  // 2-unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random hold-off before each result while rx_idle is set
  initial begin : result_side
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      hold = rx_idle ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Drive one item, after a random gap while tx_idle is set, and wait until it is taken
  task automatic send_item(op_e op, logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] x);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    channel   <= ch;
    sample    <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the input until every queued result is out, then let the unit settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Register word, optionally with junk above the register width
  function automatic logic [CFG_DATA_W-1:0] reg_word(int unsigned val, int unsigned width,
                                                     bit noisy);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << width) - 1'b1;
    if (width >= CFG_DATA_W) mask = '1;
    if (noisy) return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
    return CFG_DATA_W'(val);
  endfunction

  task automatic configure(mode_e m, int unsigned nch, int unsigned len, int unsigned decay,
                           bit noisy);
    write_reg(CFG_MODE,   reg_word(m, 1, noisy));
    write_reg(CFG_ACTIVE, reg_word(nch, NCH_W, noisy));
    write_reg(CFG_WINDOW, reg_word(len, LEN_W, noisy));
    write_reg(CFG_DECAY,  reg_word(decay, CFG_DATA_W, noisy));
    cfg_we <= 1'b0;
    cur_nch = (nch == 0) ? 1 : (nch > NUM_CH) ? NUM_CH : nch;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  // Main stimulus
  initial begin : stimulus
    int unsigned sent;
    int unsigned roll;
    int unsigned nch;
    int unsigned len;
    int unsigned decay;
    int unsigned nitems;
    logic [CHAN_W-1:0] ch;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    operation <= OP_SAMPLE;
    channel   <= '0;
    sample    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: readout with no samples, then full-scale, zero and mid-range samples, then a readout
    send_item(OP_READOUT, 3'd5, 16'hA5A5);
    send_item(OP_SAMPLE, 3'd0, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd0, 16'h0000);
    send_item(OP_SAMPLE, 3'd7, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd3, 16'h1234);
    send_item(OP_READOUT, 3'd0, 16'h0000);

    // One channel, one-sample window; sample on an inactive channel
    drain();
    configure(MODE_SMA, 1, 1, 0, 1'b0);
    send_item(OP_SAMPLE, 3'd0, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd5, 16'h5555);
    send_item(OP_SAMPLE, 3'd0, 16'h0001);
    send_item(OP_READOUT, 3'd7, 16'hFFFF);

    // Exponential with weight 1.0
    drain();
    configure(MODE_EWMA, 8, 16, 32'h10000, 1'b0);
    send_item(OP_SAMPLE, 3'd1, 16'hFFFF);
    send_item(OP_READOUT, 3'd2, 16'h0F0F);

    // Zero active count and zero window clamp to 1; weight 0 keeps nothing
    drain();
    configure(MODE_EWMA, 0, 0, 0, 1'b0);
    send_item(OP_SAMPLE, 3'd0, 16'hFFFF);
    send_item(OP_READOUT, 3'd0, 16'h0000);

    // Oversized active count, window and weight all saturate
    drain();
    configure(MODE_EWMA, 15, 31, 32'h1FFFF, 1'b0);
    send_item(OP_SAMPLE, 3'd7, 16'h8000);
    send_item(OP_SAMPLE, 3'd2, 16'hFFFF);
    send_item(OP_READOUT, 3'd4, 16'h0000);

    // Window shrunk below the write slot while the sum still holds samples
    drain();
    configure(MODE_SMA, 8, 16, 32'h08000, 1'b0);
    send_item(OP_SAMPLE, 3'd4, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd4, 16'hFFFF);
    send_item(OP_SAMPLE, 3'd4, 16'h0000);
    send_item(OP_SAMPLE, 3'd4, 16'hFFFF);
    drain();
    configure(MODE_SMA, 8, 2, 32'h08000, 1'b0);
    send_item(OP_SAMPLE, 3'd4, 16'h0001);
    send_item(OP_READOUT, 3'd1, 16'h0000);

    // Random phases; state is sometimes carried across a register change
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      roll = $urandom_range(0, 3);
      case (roll)
        0:       nch = 0;
        1:       nch = $urandom_range(9, 15);
        default: nch = $urandom_range(1, NUM_CH);
      endcase
      roll = $urandom_range(0, 5);
      case (roll)
        0:       len = 0;
        1:       len = $urandom_range(17, 31);
        2:       len = 1;
        default: len = $urandom_range(1, WIN_MAX);
      endcase
      roll = $urandom_range(0, 7);
      case (roll)
        0:       decay = 0;
        1:       decay = 32'h10000;
        2:       decay = $urandom_range(32'h10001, 32'h1FFFF);
        default: decay = $urandom_range(0, 32'h1FFFF);
      endcase
      configure(mode_e'($urandom_range(0, 1)), nch, len, decay, $urandom_range(0, 1));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      nitems = $urandom_range(15, 40);
      repeat (nitems) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_item(OP_READOUT, CHAN_W'($urandom), SAMPLE_W'($urandom));
          sent++;
        end else if (roll < 14) begin
          // any channel, possibly inactive
          ch = CHAN_W'($urandom);
          send_item(OP_SAMPLE, ch, rand_sample());
          if (ch < cur_nch) sent++;
        end else begin
          send_item(OP_SAMPLE, CHAN_W'($urandom_range(0, cur_nch - 1)), rand_sample());
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        send_item(OP_READOUT, CHAN_W'($urandom), SAMPLE_W'($urandom));
        sent++;
      end
    end

    // Wind down and give the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ multichannel_moving_average_unit.f @@
design/mma_pkg.sv
design/mma_front.sv
design/mma_queue.sv
design/mma_div.sv
design/mma_back.sv
design/multichannel_moving_average_unit.sv
test/mma_checker.sv
test/tb_top.sv
